@@ rtl/ansi_sgr_to_text_attribute_unit_defines.svh @@
// Assertion macros shared by the escape parser RTL.
`ifndef ANSI_SGR_TO_TEXT_ATTRIBUTE_UNIT_DEFINES_SVH
`define ANSI_SGR_TO_TEXT_ATTRIBUTE_UNIT_DEFINES_SVH

// Same-cycle implication under synchronous reset.
`define ASGR_ASSERT_IMP(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Next-cycle implication under synchronous reset.
`define ASGR_ASSERT_NXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/asgr_pkg.sv @@
// Shared constants, codes and controller/datapath bundles of the escape parser.
package asgr_pkg;

  localparam logic [7:0] ESC_BYTE  = 8'h1B;
  localparam logic [7:0] OPEN_BYTE = 8'h5B;
  localparam logic [7:0] SEP_BYTE  = 8'h3B;
  localparam logic [7:0] SGR_BYTE  = 8'h6D;
  localparam logic [7:0] DIGIT_LO  = 8'h30;
  localparam logic [7:0] DIGIT_HI  = 8'h39;

  localparam logic [7:0] DEFAULT_ATTR_RESET = 8'h07;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_ATTR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_ENABLE   = 1'd1;

  typedef enum logic [1:0] {
    SRC_ESC,
    SRC_BYTE,
    SRC_ATTR
  } emit_src_t;

  typedef struct packed {
    logic      accept;
    logic      clr;
    logic      sep;
    logic      digit;
    logic      apply_start;
    logic      apply_step;
    logic      emit;
    emit_src_t emit_src;
    logic      emit_last;
    logic      attr_commit;
  } cmd_t;

  typedef struct packed {
    logic is_esc;
    logic is_open;
    logic is_sep;
    logic is_digit;
    logic is_sgr;
    logic esc_en;
    logic out_free;
    logic walk_last;
    logic attr_changed;
  } sts_t;

endpackage

@@ rtl/asgr_byte_if.sv @@
// Input byte request channel.
interface asgr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

@@ rtl/asgr_result_if.sv @@
// Result request channel: passed bytes and new attributes.
interface asgr_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] value;
  logic       last;

  modport source (output valid, output kind, output value, output last, input ready);
  modport sink (input valid, input kind, input value, input last, output ready);
endinterface

@@ rtl/asgr_cfg_if.sv @@
// Configuration register write channel.
interface asgr_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [asgr_pkg::CFG_IDX_W-1:0] index;
  logic [7:0]                     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/asgr_datapath.sv @@
// Datapath: config registers, parameter store, attribute walk and result register.
`include "ansi_sgr_to_text_attribute_unit_defines.svh"

module asgr_datapath #(
  parameter int MAX_PARAMS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [7:0]                     in_byte,
  input  logic                           cfg_valid,
  input  logic [asgr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output logic                           cfg_ready,
  input  asgr_pkg::cmd_t                 cmd,
  output asgr_pkg::sts_t                 sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic [7:0]                     out_value,
  output logic                           out_last
);

  localparam int IW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CW = $clog2(MAX_PARAMS + 2);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_PARAMS);
  localparam logic [CW-1:0] CNT_ONE = CW'(1);
  localparam logic [CW-1:0] CNT_TOP = CW'(MAX_PARAMS + 1);

  function automatic logic [2:0] color_bits(input logic [2:0] m);
    color_bits = {m[0], m[1], m[2]};
  endfunction

  function automatic logic [7:0] sgr_step(input logic [7:0] a, input logic [6:0] p,
                                          input logic [7:0] dflt_attr);
    logic [7:0] r;
    logic [6:0] minor;
    r     = a;
    minor = 7'd0;
    if (p == 7'd0) begin
      r = dflt_attr;
    end else if (p == 7'd1) begin
      r = a | 8'h08;
    end else if (p == 7'd7) begin
      r = {a[3:0], a[7:4]};
    end else if (p == 7'd21 || p == 7'd22) begin
      r = a & 8'hF7;
    end else if (p >= 7'd30 && p <= 7'd39) begin
      minor = p - 7'd30;
      r = (p == 7'd39) ? ((a & 8'hF8) | (dflt_attr & 8'h07))
                       : ((a & 8'hF8) | {5'd0, color_bits(minor[2:0])});
    end else if (p >= 7'd40 && p <= 7'd49) begin
      minor = p - 7'd40;
      r = (p == 7'd49) ? ((a & 8'h8F) | (dflt_attr & 8'h70))
                       : ((a & 8'h8F) | {1'b0, color_bits(minor[2:0]), 4'd0});
    end
    sgr_step = r;
  endfunction

  logic [7:0]            byte_reg;
  logic [6:0]            store [MAX_PARAMS];
  logic [MAX_PARAMS-1:0] store_vld;
  logic [CW-1:0]         count;
  logic [IW-1:0]         widx;
  logic [7:0]            attr_work;
  logic [7:0]            current;
  logic [7:0]            dflt;
  logic                  esc_en;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] last_idx;
  logic [IW-1:0] wr_idx;
  logic [IW-1:0] rd_idx;
  logic [6:0]    rd_val;
  logic [9:0]    acc;
  logic [6:0]    sat;
  logic          room;

  assign cnt_m1   = count - CNT_ONE;
  assign wr_idx   = cnt_m1[IW-1:0];
  assign rd_idx   = cmd.apply_step ? widx : wr_idx;
  assign rd_val   = store_vld[rd_idx] ? store[rd_idx] : 7'd0;
  assign acc      = 10'(rd_val) * 10'd10 + 10'(in_byte[3:0]);
  assign sat      = (acc > 10'd99) ? 7'd99 : acc[6:0];
  assign room     = (count <= CNT_MAX);
  assign last_idx = (count > CNT_MAX) ? (CNT_MAX - CNT_ONE) : cnt_m1;

  assign cfg_ready = 1'b1;

  always_comb begin
    sts.is_esc       = (in_byte == asgr_pkg::ESC_BYTE);
    sts.is_open      = (in_byte == asgr_pkg::OPEN_BYTE);
    sts.is_sep       = (in_byte == asgr_pkg::SEP_BYTE);
    sts.is_digit     = (in_byte >= asgr_pkg::DIGIT_LO) && (in_byte <= asgr_pkg::DIGIT_HI);
    sts.is_sgr       = (in_byte == asgr_pkg::SGR_BYTE);
    sts.esc_en       = esc_en;
    sts.out_free     = !out_valid || out_ready;
    sts.walk_last    = (CW'(widx) == last_idx);
    sts.attr_changed = (attr_work != current);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dflt   <= asgr_pkg::DEFAULT_ATTR_RESET;
      esc_en <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        asgr_pkg::REG_DEFAULT_ATTR: dflt   <= cfg_data;
        asgr_pkg::REG_ESC_ENABLE:   esc_en <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_reg <= in_byte;
    end
    if (cmd.digit && room) begin
      store[wr_idx] <= sat;
    end
    if (cmd.apply_start) begin
      widx      <= '0;
      attr_work <= current;
    end else if (cmd.apply_step) begin
      widx      <= widx + IW'(1);
      attr_work <= sgr_step(attr_work, rd_val, dflt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clr) begin
      store_vld <= '0;
      count     <= CNT_ONE;
    end else begin
      if (cmd.digit && room) begin
        store_vld[wr_idx] <= 1'b1;
      end
      if (cmd.sep && room) begin
        count <= count + CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current <= asgr_pkg::DEFAULT_ATTR_RESET;
    end else if (cmd.attr_commit) begin
      current <= attr_work;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_last <= cmd.emit_last;
      case (cmd.emit_src)
        asgr_pkg::SRC_ESC: begin
          out_kind  <= 1'b0;
          out_value <= asgr_pkg::ESC_BYTE;
        end
        asgr_pkg::SRC_BYTE: begin
          out_kind  <= 1'b0;
          out_value <= byte_reg;
        end
        asgr_pkg::SRC_ATTR: begin
          out_kind  <= 1'b1;
          out_value <= attr_work;
        end
        default: begin
          out_kind  <= 1'b0;
          out_value <= byte_reg;
        end
      endcase
    end
  end

  `ASGR_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CNT_TOP, "parameter count out of range")
  `ASGR_ASSERT_NXT(a_clear_store, clk, rst, cmd.clr, count == CNT_ONE && store_vld == '0, "store not cleared")
  `ASGR_ASSERT_IMP(a_commit_change, clk, rst, cmd.attr_commit, attr_work != current, "commit without change")

endmodule

@@ rtl/asgr_ctrl.sv @@
// Controller: parse mode tracking and sequencing of emits and the attribute walk.
`include "ansi_sgr_to_text_attribute_unit_defines.svh"

module asgr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  asgr_pkg::sts_t sts,
  output asgr_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ESC_THEN_BYTE,
    S_BYTE,
    S_ESC_ONLY,
    S_APPLY,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESC,
    MODE_SEQ
  } mode_t;

  state_t state, state_next;
  mode_t  mode, mode_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    mode_next  = mode;
    cmd        = '0;
    cmd.emit_src = asgr_pkg::SRC_BYTE;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          if (!sts.esc_en) begin
            mode_next  = MODE_TEXT;
            state_next = (mode == MODE_ESC) ? S_ESC_THEN_BYTE : S_BYTE;
          end else begin
            case (mode)
              MODE_TEXT: begin
                if (sts.is_esc) begin
                  mode_next = MODE_ESC;
                end else begin
                  state_next = S_BYTE;
                end
              end
              MODE_ESC: begin
                if (sts.is_open) begin
                  cmd.clr   = 1'b1;
                  mode_next = MODE_SEQ;
                end else if (sts.is_esc) begin
                  state_next = S_ESC_ONLY;
                end else begin
                  mode_next  = MODE_TEXT;
                  state_next = S_ESC_THEN_BYTE;
                end
              end
              default: begin
                if (sts.is_sep) begin
                  cmd.sep = 1'b1;
                end else if (sts.is_digit) begin
                  cmd.digit = 1'b1;
                end else begin
                  mode_next = MODE_TEXT;
                  if (sts.is_sgr) begin
                    cmd.apply_start = 1'b1;
                    state_next      = S_APPLY;
                  end
                end
              end
            endcase
          end
        end
      end
      S_ESC_THEN_BYTE: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_src = asgr_pkg::SRC_ESC;
          state_next   = S_BYTE;
        end
      end
      S_BYTE: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_ESC_ONLY: begin
        if (sts.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_src  = asgr_pkg::SRC_ESC;
          cmd.emit_last = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_APPLY: begin
        cmd.apply_step = 1'b1;
        if (sts.walk_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!sts.attr_changed) begin
          state_next = S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_src    = asgr_pkg::SRC_ATTR;
          cmd.emit_last   = 1'b1;
          cmd.attr_commit = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= MODE_TEXT;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  `ASGR_ASSERT_IMP(a_emit_free, clk, rst, cmd.emit, sts.out_free, "emit into a full result register")
  `ASGR_ASSERT_IMP(a_walk_text, clk, rst, state == S_APPLY, mode == MODE_TEXT, "walk outside text mode")

endmodule

@@ rtl/ansi_sgr_to_text_attribute_unit.sv @@
// Top level of the escape sequence to text attribute translator.
//
// Channels: byte_ch takes one stream byte per request; result_ch returns
// passed characters (kind 0) and new attributes (kind 1), last marking the
// final result of an input byte; cfg writes default_attribute (index 0)
// and escape_enable (index 1) and is always ready.
// Flow: a plain byte is registered and then emitted from S_BYTE; a byte that
// releases a held ESC emits the ESC first and then itself (only the ESC if it
// is another ESC); an ESC from text, '[', parameter digits, ';' and other
// closing bytes emit nothing. A closing 'm' walks the stored parameters one
// per cycle through the attribute unit (at most MAX_PARAMS), then emits the
// new attribute only if it differs from the current one. A taken byte passes
// the controller state register before its emit loads the output register.
// Reset (rst, synchronous) returns to normal text mode with an empty
// parameter store and loads the default attribute of 7.
// A stalled receiver holds the result register; a byte that needs to emit
// waits for it to drain, and no new byte is taken until that emit is done.
module ansi_sgr_to_text_attribute_unit #(
  parameter int MAX_PARAMS = 16
) (
  input logic          clk,
  input logic          rst,
  asgr_byte_if.sink    byte_ch,
  asgr_result_if.source result_ch,
  asgr_cfg_if.sink     cfg
);

  asgr_pkg::cmd_t cmd;
  asgr_pkg::sts_t sts;

  asgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (byte_ch.valid),
    .in_ready (byte_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  asgr_datapath #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (byte_ch.data_byte),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .cfg_ready (cfg.ready),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (result_ch.valid),
    .out_ready (result_ch.ready),
    .out_kind  (result_ch.kind),
    .out_value (result_ch.value),
    .out_last  (result_ch.last)
  );

endmodule
